/* rtl/khe_pkg.sv */
`default_nettype none
package khe_pkg;
  localparam int TimeW = 24;
  localparam int ValW = 32;
  localparam int CntW = 7;
  localparam int LenW = 16;
  localparam int FracW = 17;
  localparam int AccW = 72;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval = 1'b1;
  localparam logic CfgKeyCount = 1'b0;
  localparam logic CfgAnimLength = 1'b1;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_WRAP,
    BK_SRCH_RD,
    BK_SRCH_CHK,
    BK_LOAD0,
    BK_LOAD1,
    BK_DIV,
    BK_COEF,
    BK_MUL,
    BK_ACC,
    BK_SAT,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic [TimeW-1:0] qtime;
  } khe_job_t;
endpackage
`default_nettype wire

/* rtl/khe_in_if.sv */
`default_nettype none
interface khe_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  key_index;
  logic [23:0] key_time;
  logic [31:0] key_value;
  logic [31:0] key_tangent;
  logic [23:0] query_time;
  modport source(output valid, command, key_index, key_time, key_value, key_tangent,
    query_time, input ready);
  modport sink(input valid, command, key_index, key_time, key_value, key_tangent,
    query_time, output ready);
endinterface
`default_nettype wire

/* rtl/khe_out_if.sv */
`default_nettype none
interface khe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] anim_value;
  modport source(output valid, anim_value, input ready);
  modport sink(input valid, anim_value, output ready);
endinterface
`default_nettype wire

/* rtl/khe_cfg_if.sv */
`default_nettype none
interface khe_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/khe_ram.sv */
`default_nettype none
module khe_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

/* rtl/khe_front.sv */
`default_nettype none
module khe_front import khe_pkg::*; #(
  parameter int MaxKeys = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  khe_in_if.sink                          in_ch,
  output logic                            key_we,
  output logic [$clog2(MaxKeys)-1:0]      key_waddr,
  output logic [TimeW+2*ValW-1:0]         key_wdata,
  output logic                            job_valid,
  output khe_job_t                        job,
  input  wire logic                       job_pop,
  input  wire logic                       back_idle
);
  localparam int AW = $clog2(MaxKeys);
  localparam int QD = 2;

  khe_job_t   q_r [QD];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, is_eval, slot_ok;

  assign is_eval = (in_ch.command == CmdEval);
  assign slot_ok = ({26'd0, in_ch.key_index} < 32'(MaxKeys));
  assign in_ch.ready = is_eval ? (cnt_r != 2'(QD)) : (back_idle && (cnt_r == 2'd0));
  assign push = in_ch.valid && in_ch.ready && is_eval;
  assign key_we = in_ch.valid && in_ch.ready && !is_eval && slot_ok;
  assign key_waddr = AW'(in_ch.key_index);
  assign key_wdata = {in_ch.key_time, in_ch.key_value, in_ch.key_tangent};
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].qtime <= in_ch.query_time;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (job_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(job_pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QD))
    else $error("queue overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> job_valid)
    else $error("pop from empty queue");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QD) && !job_pop) |=> (cnt_r == 2'(QD)))
    else $error("full queue lost item");
`endif
endmodule
`default_nettype wire

/* rtl/khe_back.sv */
`default_nettype none
module khe_back import khe_pkg::*; #(
  parameter int MaxKeys = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  job_valid,
  input  khe_job_t                   job,
  output logic                       job_pop,
  output logic                       idle,
  input  wire logic [CntW-1:0]       key_count,
  input  wire logic [LenW-1:0]       anim_len,
  output logic [$clog2(MaxKeys)-1:0] key_raddr,
  input  wire logic [TimeW+2*ValW-1:0] key_rdata,
  khe_out_if.source                  out_ch
);
  localparam int AW = $clog2(MaxKeys);
  localparam int NW = $clog2(MaxKeys+1) > CntW ? $clog2(MaxKeys+1) : CntW;
  localparam int DW = TimeW + 17;

  bk_state_t st_r, st_nxt;
  logic [TimeW-1:0] t_r, t_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [TimeW-1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  logic signed [ValW-1:0] v0_r, v0_nxt, d0_r, d0_nxt, v1_r, v1_nxt, d1_r, d1_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [FracW-1:0] u_r, u_nxt;
  logic [5:0] k_r, k_nxt;
  logic [1:0] h_r, h_nxt;
  logic signed [AccW-1:0] acc_r, acc_nxt, b_r, b_nxt, prod_r, prod_nxt;
  logic [ValW-1:0] res_r, res_nxt;
  logic ov_r, ov_nxt;

  logic [TimeW-1:0] rd_time;
  logic signed [ValW-1:0] rd_val, rd_tan;
  logic [TimeW+1:0] len8;
  logic signed [TimeW+1:0] num, den;
  logic signed [AccW-1:0] sv0, sv1, sd0, sd1, addend;
  logic signed [AccW-1:0] mul_lo;

  assign idle = (st_r == BK_IDLE);
  assign {rd_time, rd_val, rd_tan} = key_rdata;
  assign len8 = {2'b00, anim_len, 8'd0};
  assign num = $signed({2'b00, t_r}) - $signed({2'b00, t0_r});
  assign den = $signed({2'b00, t1_r}) - $signed({2'b00, t0_r});
  assign sv0 = AccW'(v0_r);
  assign sv1 = AccW'(v1_r);
  assign sd0 = AccW'(d0_r);
  assign sd1 = AccW'(d1_r);
  assign addend = (h_r == 2'd0) ? b_r : ((h_r == 2'd1) ? sd0 : sv0);
  assign mul_lo = $signed(acc_r[55:0]) * $signed({1'b0, u_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    t_r <= t_nxt; n_r <= n_nxt; i_r <= i_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    v0_r <= v0_nxt; d0_r <= d0_nxt; v1_r <= v1_nxt; d1_r <= d1_nxt;
    rem_r <= rem_nxt; u_r <= u_nxt; k_r <= k_nxt; h_r <= h_nxt;
    acc_r <= acc_nxt; b_r <= b_nxt; prod_r <= prod_nxt; res_r <= res_nxt; ov_r <= ov_nxt;
  end

  always_comb begin
    st_nxt = st_r; t_nxt = t_r; n_nxt = n_r; i_nxt = i_r; t0_nxt = t0_r; t1_nxt = t1_r;
    v0_nxt = v0_r; d0_nxt = d0_r; v1_nxt = v1_r; d1_nxt = d1_r; rem_nxt = rem_r;
    u_nxt = u_r; k_nxt = k_r; h_nxt = h_r; acc_nxt = acc_r; b_nxt = b_r;
    prod_nxt = prod_r; res_nxt = res_r; ov_nxt = ov_r;
    job_pop = 1'b0;
    key_raddr = i_r;
    out_ch.valid = (st_r == BK_OUT);
    out_ch.anim_value = res_r;
    case (st_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          t_nxt = job.qtime;
          n_nxt = (NW'(key_count) > NW'(MaxKeys)) ? NW'(MaxKeys) : NW'(key_count);
          k_nxt = 6'd0;
          st_nxt = BK_WRAP;
        end
      end
      BK_WRAP: begin
        // Restoring remainder: one shifted-subtract per cycle.
        if (len8 == '0 || k_r == 6'd16) begin
          i_nxt = AW'(0);
          key_raddr = AW'(0);
          if (n_r == '0) begin
            res_nxt = '0;
            st_nxt = BK_OUT;
          end else if (n_r == NW'(1)) begin
            st_nxt = BK_LOAD1;
            ov_nxt = 1'b1;
          end else begin
            i_nxt = AW'(1);
            key_raddr = AW'(1);
            st_nxt = BK_SRCH_RD;
          end
        end else begin
          if ({1'b0, t_r} >= ({len8[TimeW:0]} << (15 - k_r[3:0])) &&
              (len8 << (15 - k_r[3:0])) <= (TimeW+17)'(t_r)) begin
            t_nxt = t_r - TimeW'(len8 << (15 - k_r[3:0]));
          end
          k_nxt = k_r + 6'd1;
          if (k_r == 6'd15) st_nxt = BK_WRAP;
        end
        if (len8 != '0 && k_r == 6'd16) k_nxt = 6'd16;
      end
      BK_SRCH_RD: begin
        st_nxt = BK_SRCH_CHK;
      end
      BK_SRCH_CHK: begin
        if (NW'(i_r) < n_r - NW'(1) && rd_time < t_r) begin
          i_nxt = i_r + AW'(1);
          key_raddr = i_r + AW'(1);
          st_nxt = BK_SRCH_RD;
        end else begin
          t1_nxt = rd_time; v1_nxt = rd_val; d1_nxt = rd_tan;
          key_raddr = i_r - AW'(1);
          ov_nxt = 1'b0;
          st_nxt = BK_LOAD0;
        end
      end
      BK_LOAD0: begin
        key_raddr = i_r - AW'(1);
        st_nxt = BK_LOAD1;
      end
      BK_LOAD1: begin
        t0_nxt = rd_time; v0_nxt = rd_val; d0_nxt = rd_tan;
        if (ov_r) begin
          res_nxt = rd_val;
          st_nxt = BK_OUT;
        end else begin
          k_nxt = 6'd0; u_nxt = '0;
          st_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (k_r == 6'd0) begin
          if (den <= 0 || num <= 0) begin
            u_nxt = '0; st_nxt = BK_COEF;
          end else if (num >= den) begin
            u_nxt = FracW'(65536); st_nxt = BK_COEF;
          end else begin
            rem_nxt = DW'(num); k_nxt = 6'd1;
          end
        end else begin
          if ({rem_r[DW-2:0], 1'b0} >= DW'(den)) begin
            rem_nxt = {rem_r[DW-2:0], 1'b0} - DW'(den);
            u_nxt = {u_r[FracW-2:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[DW-2:0], 1'b0};
            u_nxt = {u_r[FracW-2:0], 1'b0};
          end
          k_nxt = k_r + 6'd1;
          if (k_r == 6'd16) st_nxt = BK_COEF;
        end
      end
      BK_COEF: begin
        acc_nxt = ((sv0 - sv1) <<< 1) + sd0 + sd1;
        b_nxt = (sv1 - sv0) * 3 - (sd0 <<< 1) - sd1;
        h_nxt = 2'd0;
        st_nxt = BK_MUL;
      end
      BK_MUL: begin
        prod_nxt = mul_lo;
        st_nxt = BK_ACC;
      end
      BK_ACC: begin
        acc_nxt = (prod_r >>> 16) + addend;
        h_nxt = h_r + 2'd1;
        st_nxt = (h_r == 2'd2) ? BK_SAT : BK_MUL;
      end
      BK_SAT: begin
        if (acc_r > 72'sd2147483647) res_nxt = 32'h7FFF_FFFF;
        else if (acc_r < -72'sd2147483648) res_nxt = 32'h8000_0000;
        else res_nxt = acc_r[31:0];
        st_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (out_ch.ready) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
    if (st_r == BK_WRAP) begin
      key_raddr = (n_r > NW'(1) && (len8 == '0 || k_r == 6'd16)) ? AW'(1) : AW'(0);
    end
  end

`ifndef SYNTHESIS
  a_outhold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.anim_value)))
    else $error("result dropped");
  a_popidle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (st_r == BK_IDLE))
    else $error("pop while busy");
  a_u: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_MUL) |-> (u_r <= FracW'(65536)))
    else $error("fraction out of range");
`endif
endmodule
`default_nettype wire

/* rtl/keyframe_hermite_evaluator_unit.sv */
// An evaluate item runs in steps: its query time is wrapped, the keys are searched (each key is
// read, then checked), the bracketing keys are loaded and a divider forms the segment fraction.
// Horner uses three multiply/add passes, then the result saturates to 32 bits; one evaluation runs at a time.
// A write item is accepted only while no evaluation is queued or running; it lands at once.
// Synchronous active-low reset clears control and config; key stores are not cleared.
`default_nettype none
module keyframe_hermite_evaluator_unit import khe_pkg::*; #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  khe_in_if.sink    in_ch,
  khe_out_if.source out_ch,
  khe_cfg_if.sink   cfg_ch
);
  localparam int AW = $clog2(MAX_KEYS);
  logic [CntW-1:0] key_count_r;
  logic [LenW-1:0] anim_len_r;
  logic key_we, job_valid, job_pop, back_idle;
  logic [AW-1:0] waddr, raddr;
  logic [TimeW+2*ValW-1:0] wdata, rdata;
  khe_job_t job;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
      anim_len_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CfgKeyCount) key_count_r <= cfg_ch.data[CntW-1:0];
      else anim_len_r <= cfg_ch.data[LenW-1:0];
    end
  end

  khe_front #(.MaxKeys(MAX_KEYS)) u_front (
    .clk, .rst_n, .in_ch, .key_we, .key_waddr(waddr), .key_wdata(wdata),
    .job_valid, .job, .job_pop, .back_idle);

  khe_ram #(.Width(TimeW+2*ValW), .Depth(MAX_KEYS)) u_ram (
    .clk, .we(key_we), .waddr, .wdata, .raddr, .rdata);

  khe_back #(.MaxKeys(MAX_KEYS)) u_back (
    .clk, .rst_n, .job_valid, .job, .job_pop, .idle(back_idle), .key_count(key_count_r),
    .anim_len(anim_len_r), .key_raddr(raddr), .key_rdata(rdata), .out_ch);
endmodule
`default_nettype wire
